### hw/rtl/assert_macros.svh
// assertion macros for the windowed rms loudness block
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge outside reset
`define WRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every rising edge, reset included
`define WRL_ASSERT_RESET(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hw/rtl/wrl_pkg.sv
// shared constants, payload types and helper functions for the loudness meter
// no dependencies
`default_nettype none

package wrl_pkg;

  // sizes
  localparam int MAX_CHANNELS = 8;
  localparam int MAX_WINDOW   = 32768;
  localparam int SAMPLE_BITS  = 24;

  localparam int CH_W    = $clog2(MAX_CHANNELS);
  localparam int CNT_W   = CH_W + 1;
  localparam int POS_W   = $clog2(MAX_WINDOW);
  localparam int WIN_W   = POS_W + 1;
  localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
  localparam int SUM_W   = 61;
  localparam int TOT_W   = 64;
  localparam int QUOT_W  = 50;
  localparam int ROOT_W  = TOT_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int GAIN_W  = 16;
  localparam int PROD_W  = ROOT_W + GAIN_W;
  localparam int LEVEL_W = 25;
  localparam int LEVEL_SHIFT = 23;
  localparam int DIV_CNT_W   = $clog2(TOT_W);
  localparam int RING_AW     = CH_W + POS_W;
  localparam int RING_DEPTH  = 1 << RING_AW;
  localparam int QD_W        = 2;
  localparam int QUEUE_DEPTH = 1 << QD_W;

  // arithmetic constants
  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
  localparam logic [QUOT_W-1:0] QUOT_MAX = '1;
  localparam logic [GAIN_W-1:0] GAIN_Q16 = 16'd60522;

  // register map, word index taken from paddr[2]
  localparam int PADDR_W = 3;
  localparam logic REG_WINDOW   = 1'b0;
  localparam logic REG_CHANNELS = 1'b1;
  localparam logic [WIN_W-1:0] WINDOW_RESET   = 16'd19200;
  localparam logic [CNT_W-1:0] CHANNELS_RESET = 4'd2;

  // input item
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [CH_W-1:0]               channel;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               warming;
  } out_item_t;

  // classified sample between front and back
  typedef struct packed {
    logic [SQ_W-1:0] sq;
    logic [CH_W-1:0] ch;
    logic            last;
  } sq_entry_t;

  // frame job for the level unit
  typedef struct packed {
    logic [TOT_W-1:0] total;
    logic [WIN_W-1:0] win;
    logic             warming;
  } level_job_t;

  // window length with out-of-range values folded in
  function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] wl);
    logic [WIN_W-1:0] res;
    if (wl == '0) begin
      res = WIN_W'(1);
    end else if (wl > WIN_W'(MAX_WINDOW)) begin
      res = WIN_W'(MAX_WINDOW);
    end else begin
      res = wl;
    end
    return res;
  endfunction

  // channel count with out-of-range values folded in
  function automatic logic [CNT_W-1:0] eff_channels(input logic [CNT_W-1:0] cc);
    logic [CNT_W-1:0] res;
    if (cc == '0) begin
      res = CNT_W'(1);
    end else if (cc > CNT_W'(MAX_CHANNELS)) begin
      res = CNT_W'(MAX_CHANNELS);
    end else begin
      res = cc;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/wrl_front.sv
// front end: takes input transactions, drops channels beyond the count, squares the sample
// depends on wrl_pkg
`default_nettype none

module wrl_front import wrl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_busy_i,
  input  logic [CNT_W-1:0] chan_cnt_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output sq_entry_t        push_data_o
);

  logic                     stg_valid_q, stg_valid_d;
  sq_entry_t                stg_q;
  logic [SAMPLE_BITS-1:0]   raw;
  logic [SAMPLE_BITS-1:0]   mag;
  logic [2*SAMPLE_BITS-1:0] prod;
  logic [CNT_W-1:0]         chan_ext;
  logic                     keep;
  logic                     in_fire;

  // magnitude and square; the most negative code maps to 2^(bits-1)
  assign raw  = in_data_i.sample;
  assign mag  = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
  assign prod = mag * mag;

  // classification
  assign chan_ext = {1'b0, in_data_i.channel};
  assign keep     = chan_ext < chan_cnt_i;

  // handshake
  assign in_ready_o   = !clr_busy_i && (!stg_valid_q || push_ready_i);
  assign in_fire      = in_valid_i && in_ready_o;
  assign push_valid_o = stg_valid_q;
  assign push_data_o  = stg_q;

  // stage occupancy
  always_comb begin
    stg_valid_d = stg_valid_q;
    if (in_fire) begin
      stg_valid_d = keep;
    end else if (push_ready_i) begin
      stg_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (in_fire && keep) begin
      stg_q.sq   <= prod[SQ_W-1:0];
      stg_q.ch   <= in_data_i.channel;
      stg_q.last <= (chan_ext == (chan_cnt_i - CNT_W'(1)));
    end
  end

endmodule

`default_nettype wire

### hw/rtl/wrl_fifo.sv
// short queue of squared samples between front and back
// depends on wrl_pkg
`default_nettype none

module wrl_fifo import wrl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  sq_entry_t push_data_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output sq_entry_t pop_data_o
);

  logic [QD_W:0]   count_q, count_d;
  logic [QD_W-1:0] wr_ptr_q, rd_ptr_q;
  sq_entry_t       slot_q [QUEUE_DEPTH];
  logic            push_fire, pop_fire;

  assign push_ready_o = count_q != (QD_W+1)'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;

  // occupancy
  always_comb begin
    count_d = count_q;
    if (push_fire && !pop_fire) begin
      count_d = count_q + (QD_W+1)'(1);
    end else if (pop_fire && !push_fire) begin
      count_d = count_q - (QD_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      count_q <= count_d;
      if (push_fire) begin
        wr_ptr_q <= wr_ptr_q + QD_W'(1);
      end
      if (pop_fire) begin
        rd_ptr_q <= rd_ptr_q + QD_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/wrl_back.sv
// back end: ring clearing after reset, square ring read-modify-write, per-channel window sums, frame totals
// depends on wrl_pkg; hands finished frames to the level unit
`default_nettype none

module wrl_back import wrl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WIN_W-1:0] win_i,
  input  logic [CNT_W-1:0] chan_cnt_i,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  sq_entry_t        pop_data_i,
  output logic             clr_busy_o,
  output logic             job_valid_o,
  input  logic             job_ready_i,
  output level_job_t       job_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RMW   = 3'd2;
  localparam logic [2:0] ST_TOT   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [RING_AW-1:0] clr_cnt_q;
  sq_entry_t          cur_q;
  logic [POS_W-1:0]   pos_q;
  logic [WIN_W-1:0]   seen_q;
  logic [SUM_W-1:0]   sum_q [MAX_CHANNELS];
  logic [TOT_W-1:0]   tot_q;
  logic [CH_W-1:0]    k_q;

  // ring memory
  logic [SQ_W-1:0]    ring_mem [RING_DEPTH];
  logic [SQ_W-1:0]    ring_rdata_q;
  logic               mem_we;
  logic [RING_AW-1:0] mem_waddr;
  logic [SQ_W-1:0]    mem_wdata;
  logic [RING_AW-1:0] mem_raddr;

  logic [CH_W-1:0]    sum_idx;
  logic [SUM_W-1:0]   sum_rd;
  logic [SUM_W:0]     grown;
  logic [SUM_W:0]     old_ext;
  logic [SUM_W:0]     diff;
  logic [SUM_W-1:0]   sum_new;
  logic [CH_W-1:0]    k_last;
  logic [WIN_W-1:0]   seen_inc;
  logic [WIN_W-1:0]   pos_inc;
  logic [POS_W-1:0]   pos_next;
  logic               pop_fire;
  logic               job_fire;

  assign pop_ready_o = state_q == ST_IDLE;
  assign pop_fire    = pop_valid_i && pop_ready_o;
  assign clr_busy_o  = state_q == ST_CLEAR;
  assign job_valid_o = state_q == ST_FIN;
  assign job_fire    = job_valid_o && job_ready_i;

  // memory port selection: clearing sweep or sample write-back
  assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_RMW);
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : {cur_q.ch, pos_q};
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : cur_q.sq;
  assign mem_raddr = {pop_data_i.ch, pos_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    ring_rdata_q <= ring_mem[mem_raddr];
  end

  // window sum update: add new square, drop the overwritten one, clamp both ends
  assign sum_idx = (state_q == ST_TOT) ? k_q : cur_q.ch;
  assign sum_rd  = sum_q[sum_idx];
  assign grown   = {1'b0, sum_rd} + (SUM_W+1)'(cur_q.sq);
  assign old_ext = (SUM_W+1)'(ring_rdata_q);
  assign diff    = grown - old_ext;

  always_comb begin
    if (grown < old_ext) begin
      sum_new = '0;
    end else if (diff[SUM_W]) begin
      sum_new = SUM_MAX;
    end else begin
      sum_new = diff[SUM_W-1:0];
    end
  end

  // frame end bookkeeping
  assign k_last   = CH_W'(chan_cnt_i - CNT_W'(1));
  assign seen_inc = (seen_q < WIN_W'(MAX_WINDOW)) ? (seen_q + WIN_W'(1)) : seen_q;
  assign pos_inc  = {1'b0, pos_q} + WIN_W'(1);
  assign pos_next = (pos_inc >= win_i) ? '0 : pos_inc[POS_W-1:0];

  assign job_o.total   = tot_q;
  assign job_o.win     = win_i;
  assign job_o.warming = seen_inc < win_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (&clr_cnt_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop_fire) begin
          state_d = ST_RMW;
        end
      end
      ST_RMW: begin
        state_d = cur_q.last ? ST_TOT : ST_IDLE;
      end
      ST_TOT: begin
        if (k_q == k_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (job_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      pos_q     <= '0;
      seen_q    <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        sum_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + RING_AW'(1);
      end
      if (state_q == ST_RMW) begin
        sum_q[cur_q.ch] <= sum_new;
      end
      if (job_fire) begin
        pos_q  <= pos_next;
        seen_q <= seen_inc;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_fire) begin
      cur_q <= pop_data_i;
    end
    if (state_q == ST_RMW) begin
      tot_q <= '0;
      k_q   <= '0;
    end else if (state_q == ST_TOT) begin
      tot_q <= tot_q + TOT_W'(sum_rd);
      k_q   <= k_q + CH_W'(1);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/wrl_level.sv
// level unit: total / window by restoring division, floor root, gain scale
// depends on wrl_pkg; holds the output register toward the result channel
`default_nettype none

module wrl_level import wrl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  output logic       job_ready_o,
  input  level_job_t job_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o
);

  localparam logic [2:0] LV_IDLE = 3'd0;
  localparam logic [2:0] LV_DIV  = 3'd1;
  localparam logic [2:0] LV_PREP = 3'd2;
  localparam logic [2:0] LV_ROOT = 3'd3;
  localparam logic [2:0] LV_MUL  = 3'd4;
  localparam logic [2:0] LV_DONE = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [TOT_W-1:0]     acc_q;
  logic [REM_W-1:0]     rem_q;
  logic [ROOT_W-1:0]    root_q;
  logic [WIN_W-1:0]     win_q;
  logic                 warm_q;
  logic [PROD_W-1:0]    prod_q;
  logic                 out_valid_q;
  out_item_t            out_q;

  logic [WIN_W:0]       div_sh;
  logic                 div_ge;
  logic [WIN_W:0]       div_rem;
  logic [REM_W-1:0]     rt_sh;
  logic [REM_W-1:0]     rt_trial;
  logic                 rt_ge;
  logic                 job_fire;
  logic                 out_load;

  assign job_ready_o = state_q == LV_IDLE;
  assign job_fire    = job_valid_i && job_ready_o;
  assign out_load    = (state_q == LV_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // one quotient bit per cycle
  assign div_sh  = {rem_q[WIN_W-1:0], acc_q[TOT_W-1]};
  assign div_ge  = div_sh >= {1'b0, win_q};
  assign div_rem = div_ge ? (div_sh - {1'b0, win_q}) : div_sh;

  // one root bit per cycle, radicand enters two bits at a time
  assign rt_sh    = {rem_q[ROOT_W-1:0], acc_q[TOT_W-1 -: 2]};
  assign rt_trial = {root_q, 2'b01};
  assign rt_ge    = rt_sh >= rt_trial;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      LV_IDLE: begin
        if (job_fire) begin
          state_d = job_i.warming ? LV_DONE : LV_DIV;
        end
      end
      LV_DIV: begin
        if (cnt_q == '0) begin
          state_d = LV_PREP;
        end
      end
      LV_PREP: begin
        state_d = LV_ROOT;
      end
      LV_ROOT: begin
        if (cnt_q == '0) begin
          state_d = LV_MUL;
        end
      end
      LV_MUL: begin
        state_d = LV_DONE;
      end
      LV_DONE: begin
        if (out_load) begin
          state_d = LV_IDLE;
        end
      end
      default: begin
        state_d = LV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= LV_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      LV_IDLE: begin
        if (job_fire) begin
          acc_q  <= job_i.total;
          win_q  <= job_i.win;
          warm_q <= job_i.warming;
          rem_q  <= '0;
          cnt_q  <= DIV_CNT_W'(TOT_W - 1);
          prod_q <= '0;
        end
      end
      LV_DIV: begin
        acc_q <= {acc_q[TOT_W-2:0], div_ge};
        rem_q <= REM_W'(div_rem);
        cnt_q <= cnt_q - DIV_CNT_W'(1);
      end
      LV_PREP: begin
        // clamp the quotient, then scale by 2^14 for the root
        if (|acc_q[TOT_W-1:QUOT_W]) begin
          acc_q <= {QUOT_MAX, (TOT_W-QUOT_W)'(0)};
        end else begin
          acc_q <= {acc_q[QUOT_W-1:0], (TOT_W-QUOT_W)'(0)};
        end
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= DIV_CNT_W'(ROOT_W - 1);
      end
      LV_ROOT: begin
        acc_q  <= {acc_q[TOT_W-3:0], 2'b00};
        rem_q  <= rt_ge ? (rt_sh - rt_trial) : rt_sh;
        root_q <= {root_q[ROOT_W-2:0], rt_ge};
        cnt_q  <= cnt_q - DIV_CNT_W'(1);
      end
      LV_MUL: begin
        // root * gain stays below 2^48, so the shifted level fits without clamping
        prod_q <= root_q * GAIN_Q16;
      end
      LV_DONE: begin
        if (out_load) begin
          out_q.level   <= prod_q[LEVEL_SHIFT +: LEVEL_W];
          out_q.warming <= warm_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/windowed_rms_loudness.sv
// Windowed RMS loudness meter, multichannel, sliding window over window_length frames.
// Input channel: valid/ready, one signed sample per transaction, channels interleaved in
// order; a transaction with channel >= channel_count is taken and dropped.
// Output channel: valid/ready, one result per frame, sent when channel channel_count-1
// arrives: level = floor(isqrt((total/W) << 14) * 60522 >> 23), zero while warming.
// Config: APB registers window_length (0x0) and channel_count (0x4), written while idle.
// Per sample the back end does the ring read-modify-write: one memory read as it takes
// the sample in the idle state, one write in the RMW state. A frame end then adds up
// the channel sums one by one in the TOT state. Outside the warm-up the level unit
// runs 64 division steps, 32 root steps and one multiply; that unit bounds the
// sustained frame rate. A frame result passes the queue, the back end's RMW, TOT and
// FIN states and the level unit, which skips division, root and multiply while warming.
// After reset the ring (262144 entries) is cleared one entry per cycle; input ready
// stays low throughout the clearing while config writes are still taken.
// When the receiver stalls, one result waits in the output register, the level unit
// holds a second, and the back end and a four-deep queue keep taking samples until full.
// depends on wrl_pkg, wrl_front, wrl_fifo, wrl_back, wrl_level, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module windowed_rms_loudness import wrl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input samples
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  // results
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [WIN_W-1:0] window_length_q;
  logic [CNT_W-1:0] channel_count_q;
  logic [WIN_W-1:0] win_eff;
  logic [CNT_W-1:0] chan_eff;
  logic             cfg_write;

  logic             clr_busy;
  logic             push_valid, push_ready;
  sq_entry_t        push_data;
  logic             pop_valid, pop_ready;
  sq_entry_t        pop_data;
  logic             job_valid, job_ready;
  level_job_t       job;
  logic             warm_out;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= WINDOW_RESET;
      channel_count_q <= CHANNELS_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_WINDOW) begin
        window_length_q <= pwdata[WIN_W-1:0];
      end else begin
        channel_count_q <= pwdata[CNT_W-1:0];
      end
    end
  end

  // register readback
  always_comb begin
    case (paddr[2])
      REG_WINDOW:   prdata = 32'(window_length_q);
      REG_CHANNELS: prdata = 32'(channel_count_q);
      default:      prdata = '0;
    endcase
  end

  assign win_eff  = eff_window(window_length_q);
  assign chan_eff = eff_channels(channel_count_q);

  // front end
  wrl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clr_busy_i   (clr_busy),
    .chan_cnt_i   (chan_eff),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // queue between front and back
  wrl_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // back end
  wrl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_i       (win_eff),
    .chan_cnt_i  (chan_eff),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .clr_busy_o  (clr_busy),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  // level computation and output register
  wrl_level u_level (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // checks
  assign warm_out = out_valid_o && out_data_o.warming;

  `WRL_ASSERT_RESET(a_reset_quiet, !rst_ni |-> !(out_valid_o || in_ready_o), "busy in reset")
  `WRL_ASSERT(a_clear_blocks_input, clr_busy |-> !in_ready_o, "input taken during ring clearing")
  `WRL_ASSERT(a_level_one_job, (job_valid && job_ready) |=> !job_ready, "level unit overrun")
  `WRL_ASSERT(a_warming_zero, warm_out |-> (out_data_o.level == '0), "level set while warming")

endmodule

`default_nettype wire

### test/tb.sv
// self-checking testbench for windowed_rms_loudness: samples over valid/ready, levels checked
// against an in-bench level predictor, register writes over the apb-style port
// depends on wrl_pkg and the windowed_rms_loudness rtl
`default_nettype none

module tb;
  import wrl_pkg::*;

  localparam int SETTLE_CYCLES  = 300;
  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_SAMPLES  = 132;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  // one line of the directed table
  typedef struct packed {
    row_kind_e kind;
    logic      reg_sel;
    logic [15:0] value;
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // predictor state
  longint unsigned square_mem [0:MAX_CHANNELS*MAX_WINDOW-1];
  longint unsigned chan_sum [0:MAX_CHANNELS-1];
  int unsigned slot_pos = 0;
  int unsigned frame_cnt = 0;
  logic [15:0] win_cfg = 16'd19200;
  logic [3:0] chan_cfg = 4'd2;

  out_item_t level_queue[$];
  stim_row_t directed_rows[$];

  int fail_cnt = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  windowed_rms_loudness dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #2 clk_i = ~clk_i;

  // folded register values
  function automatic int unsigned active_window();
    if (win_cfg == 16'd0) return 1;
    if (win_cfg > 16'(MAX_WINDOW)) return MAX_WINDOW;
    return win_cfg;
  endfunction

  function automatic int unsigned active_channels();
    if (chan_cfg == 4'd0) return 1;
    if (chan_cfg > 4'(MAX_CHANNELS)) return MAX_CHANNELS;
    return chan_cfg;
  endfunction

  // integer floor square root, one result bit per step
  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned r;
    longint unsigned cand;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (cand * cand <= x) r = cand;
    end
    return r;
  endfunction

  // updates the window state for one sample, returns 1 when a frame level comes out
  function automatic bit predict_level(input in_item_t it, output out_item_t res);
    int unsigned w;
    int unsigned c;
    int unsigned ch;
    int unsigned slot;
    longint sv;
    longint unsigned sq, old, s, tot, q, r, lv;
    logic [64:0] acc;
    w = active_window();
    c = active_channels();
    ch = it.channel;
    res = '0;
    if (ch >= c) return 0;
    sv = $signed(it.sample);
    sq = longint'(sv * sv);
    slot = ch * MAX_WINDOW + slot_pos;
    old = square_mem[slot];
    s = chan_sum[ch] + sq;
    s = (s < old) ? 64'd0 : s - old;
    if (s > SUM_MAX) s = SUM_MAX;
    chan_sum[ch] = s;
    square_mem[slot] = sq;
    if (ch != c - 1) return 0;
    // frame end: add up all channel sums
    tot = 0;
    for (int k = 0; k < c; k++) begin
      acc = {1'b0, tot} + {1'b0, chan_sum[k]};
      tot = acc[64] ? '1 : acc[63:0];
    end
    slot_pos++;
    if (slot_pos >= w) slot_pos = 0;
    if (frame_cnt < MAX_WINDOW) frame_cnt++;
    res.warming = (frame_cnt < w);
    if (!res.warming) begin
      q = tot / w;
      if (q > QUOT_MAX) q = QUOT_MAX;
      r = floor_root(q << 14);
      lv = (r * GAIN_Q16) >> LEVEL_SHIFT;
      if (lv > 64'h1FF_FFFF) lv = 64'h1FF_FFFF;
      res.level = lv[LEVEL_W-1:0];
    end
    return 1;
  endfunction

  function automatic logic [23:0] pick_sample();
    logic [23:0] tiny;
    tiny = 24'($urandom_range(0, 511));
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      3: return tiny - 24'd256;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic stim_row_t cfg_row(input logic sel, input logic [15:0] value);
    stim_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.reg_sel = sel;
    row.value = value;
    return row;
  endfunction

  function automatic stim_row_t smp_row(input logic [23:0] sample, input logic [2:0] ch);
    stim_row_t row;
    row = '0;
    row.kind = ROW_SAMPLE;
    row.item.sample = sample;
    row.item.channel = ch;
    return row;
  endfunction

  // frame end while the window is still filling: level 0, warming set
  function automatic stim_row_t warm_row(input logic [23:0] sample, input logic [2:0] ch);
    stim_row_t row;
    row = smp_row(sample, ch);
    row.typed = 1'b1;
    row.want.level = '0;
    row.want.warming = 1'b1;
    return row;
  endfunction

  // append one row to the directed table
  task automatic add_row(input stim_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_SEND: begin
        send_gap_pct = 71;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_gap_pct = 0;
        recv_stall_pct = 71;
      end
      IDLE_BOTH: begin
        send_gap_pct = 19;
        recv_stall_pct = 19;
      end
      default: begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // one sample transaction; entered and left at a falling edge
  task automatic push_sample(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t res;
    bit has_res;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (!in_ready);
    samples_sent++;
    has_res = predict_level(it, res);
    if (has_res) level_queue.insert(level_queue.size(), typed ? want : res);
    @(negedge clk_i);
  endtask

  // register write: setup then access cycle
  task automatic reg_write(input logic sel, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (sel == REG_WINDOW) win_cfg = value;
    else chan_cfg = value[3:0];
    settings_used++;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  // let every expected level come out, then let the back end settle
  task automatic drain_idle();
    in_valid <= 1'b0;
    while (level_queue.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (level_queue.size() == 0) begin
        $error("level transaction with nothing expected: level %0d warming %0d",
               out_data.level, out_data.warming);
        fail_cnt++;
      end else begin
        want = level_queue.pop_front();
        if (out_data.level !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, out_data.level);
          fail_cnt++;
        end
        if (out_data.warming !== want.warming) begin
          $error("warming: expected %0d, got %0d", want.warming, out_data.warming);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction, ring clearing included
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d cycles without a transaction", idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t row;
    in_item_t it;
    logic [15:0] wl;
    logic [3:0] cc;
    int counted;
    int next_ch;
    int c_eff;

    // directed table
    add_row(smp_row(24'h7FFFFF, 3'd0));
    add_row(warm_row(24'h800000, 3'd1));
    add_row(smp_row(24'h000000, 3'd5));
    add_row(smp_row(24'hFFFFFF, 3'd7));
    add_row(warm_row(24'h000001, 3'd1));
    add_row(cfg_row(REG_CHANNELS, 16'd15));
    add_row(cfg_row(REG_WINDOW, 16'd65535));
    add_row(smp_row(24'h7FFFFF, 3'd0));
    add_row(smp_row(24'h800000, 3'd1));
    add_row(smp_row(24'h555555, 3'd2));
    add_row(smp_row(24'hAAAAAA, 3'd3));
    add_row(smp_row(24'h000001, 3'd4));
    add_row(smp_row(24'hFFFFFF, 3'd5));
    add_row(smp_row(24'h400000, 3'd6));
    add_row(warm_row(24'h3FFFFF, 3'd7));
    add_row(cfg_row(REG_WINDOW, 16'd0));
    add_row(cfg_row(REG_CHANNELS, 16'd0));
    add_row(smp_row(24'h800000, 3'd0));
    add_row(smp_row(24'h7FFFFF, 3'd4));
    add_row(smp_row(24'h7FFFFF, 3'd0));
    add_row(cfg_row(REG_WINDOW, 16'd32768));
    add_row(cfg_row(REG_CHANNELS, 16'd8));
    add_row(warm_row(24'h123456, 3'd7));
    add_row(cfg_row(REG_WINDOW, 16'd2));
    add_row(cfg_row(REG_CHANNELS, 16'd3));
    add_row(smp_row(24'h654321, 3'd0));
    add_row(smp_row(24'h800000, 3'd1));
    add_row(smp_row(24'h7FFFFF, 3'd2));

    // reset
    set_idle(IDLE_NONE);
    rst_ni <= 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, under the reset register values at first
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        drain_idle();
        reg_write(row.reg_sel, row.value);
      end else begin
        push_sample(row.item, row.typed, row.want);
      end
    end

    // random phases: mostly well-formed frames, some stray channels
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_idle();
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: wl = 16'd0;
          1: wl = 16'd1;
          2: wl = 16'd32768;
          default: wl = 16'($urandom_range(32769, 65535));
        endcase
      end else begin
        wl = 16'($urandom_range(1, 24));
      end
      cc = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
      reg_write(REG_WINDOW, wl);
      reg_write(REG_CHANNELS, {12'd0, cc});
      set_idle(idle_mode_e'(ph % 4));
      c_eff = active_channels();
      counted = 0;
      next_ch = 0;
      while (counted < PHASE_SAMPLES) begin
        it.sample = pick_sample();
        if ($urandom_range(0, 99) < 85) begin
          it.channel = 3'(next_ch);
          next_ch = (next_ch + 1) % c_eff;
        end else begin
          it.channel = 3'($urandom_range(0, 7));
        end
        if (it.channel < c_eff) counted++;
        push_sample(it, 1'b0, '0);
      end
    end

    drain_idle();
    $display("covered %0d samples and %0d levels across %0d register writes",
             samples_sent, results_seen, settings_used);
    $display("idle modes: none, sender gaps, receiver stalls, both");
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
